FILE: rtl/law_pkg.sv
package law_pkg;

	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int XW          = $clog2(GRID_WIDTH);
	localparam int YW          = $clog2(GRID_HEIGHT);
	localparam int ADDR_W      = XW + YW;
	localparam int GRID_SITES  = GRID_WIDTH * GRID_HEIGHT;
	localparam int CNT_W       = 13;
	localparam int COUNT_MAX   = 8191;
	localparam int COUNT_LIMIT = (GRID_SITES < COUNT_MAX) ? GRID_SITES : COUNT_MAX;
	localparam int IDX_W       = 3;
	localparam int NB_LAST     = 4;

	typedef enum logic [1:0] {
		SITE_EMPTY    = 2'd0,
		SITE_OCCUPIED = 2'd1,
		SITE_OPEN     = 2'd2
	} site_t;

	typedef enum logic [1:0] {
		OP_SEED  = 2'd0,
		OP_OPEN  = 2'd1,
		OP_ENTER = 2'd2,
		OP_WALK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_XM = 2'd0,
		DIR_XP = 2'd1,
		DIR_YP = 2'd2,
		DIR_YM = 2'd3
	} dir_t;

	typedef enum logic [2:0] {
		ST_WRITTEN     = 3'd0,
		ST_REJECTED    = 3'd1,
		ST_WALKING     = 3'd2,
		ST_STUCK       = 3'd3,
		ST_ESCAPED     = 3'd4,
		ST_NO_PARTICLE = 3'd5,
		ST_BUSY        = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_READ  = 4'b0100,
		S_FIN   = 4'b1000
	} fsm_t;

	function automatic logic [XW-1:0] dec_x(input logic [XW-1:0] x);
		return (x == '0) ? XW'(GRID_WIDTH - 1) : x - XW'(1);
	endfunction

	function automatic logic [XW-1:0] inc_x(input logic [XW-1:0] x);
		return (x == XW'(GRID_WIDTH - 1)) ? '0 : x + XW'(1);
	endfunction

	function automatic logic [YW-1:0] dec_y(input logic [YW-1:0] y);
		return (y == '0) ? YW'(GRID_HEIGHT - 1) : y - YW'(1);
	endfunction

	function automatic logic [YW-1:0] inc_y(input logic [YW-1:0] y);
		return (y == YW'(GRID_HEIGHT - 1)) ? '0 : y + YW'(1);
	endfunction

endpackage

FILE: rtl/lattice_aggregation_walker.sv
// Diffusion-limited aggregation on a 64 x 64 toroidal grid held in one
// synchronous site memory (one write and one read per cycle, read data
// registered). After reset the block sweeps all 4096 sites to empty, one a
// cycle, and takes no word until that is done. Seed, open, busy and
// no-particle words go from accept straight to the result state; enter words
// with no active particle and walk words with one first read the target site
// and its four neighbours through the single read port, one a cycle. One word
// is in work at a time; the next is accepted while a result waits on the output.
module lattice_aggregation_walker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              operation,
	input  logic [5:0]              pos_x,
	input  logic [5:0]              pos_y,
	input  logic [1:0]              direction,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2:0]              status,
	output logic [5:0]              cur_x,
	output logic [5:0]              cur_y,
	output logic [12:0]             occupied_total,
	output logic [12:0]             open_total
);

	law_pkg::fsm_t                      state_q;
	logic [law_pkg::IDX_W-1:0]          idx_q;
	logic [law_pkg::ADDR_W-1:0]         clr_addr_q;
	logic                               active_q;
	logic [law_pkg::XW-1:0]             walker_x_q;
	logic [law_pkg::YW-1:0]             walker_y_q;
	logic [law_pkg::CNT_W-1:0]          occ_cnt_q;
	logic [law_pkg::CNT_W-1:0]          open_cnt_q;
	logic                               out_valid_q;

	law_pkg::op_t                       op_q;
	logic [law_pkg::XW-1:0]             tx_q;
	logic [law_pkg::YW-1:0]             ty_q;
	law_pkg::site_t                     center_q;
	logic                               nb_occ_q;
	law_pkg::site_t                     rd_data_q;
	law_pkg::status_t                   status_q;
	logic [law_pkg::XW-1:0]             cur_x_q;
	logic [law_pkg::YW-1:0]             cur_y_q;

	law_pkg::site_t                     grid_mem [law_pkg::GRID_SITES];

	logic                               accept;
	logic                               fin_go;
	law_pkg::op_t                       op_in;
	law_pkg::dir_t                      dir_in;
	logic [law_pkg::XW-1:0]             mv_x;
	logic [law_pkg::YW-1:0]             mv_y;
	logic [law_pkg::XW-1:0]             nx_x;
	logic [law_pkg::YW-1:0]             nx_y;
	logic                               need_read;

	logic                               occ_any;
	law_pkg::status_t                   res_status;
	logic                               do_write;
	law_pkg::site_t                     write_val;
	logic                               bump_occ;
	logic                               bump_open;
	logic                               set_active;
	logic                               clr_active;
	logic                               move_walker;

	logic                               mem_we;
	logic [law_pkg::ADDR_W-1:0]         mem_waddr;
	law_pkg::site_t                     mem_wdata;
	logic                               mem_re;
	logic [law_pkg::ADDR_W-1:0]         mem_raddr;

	assign in_ready       = (state_q == law_pkg::S_IDLE);
	assign accept         = in_valid && in_ready;
	assign fin_go         = !out_valid_q || out_ready;
	assign op_in          = law_pkg::op_t'(operation);
	assign dir_in         = law_pkg::dir_t'(direction);

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign cur_x          = cur_x_q;
	assign cur_y          = cur_y_q;
	assign occupied_total = occ_cnt_q;
	assign open_total     = open_cnt_q;

	// target site of the incoming word
	always_comb begin
		mv_x = walker_x_q;
		mv_y = walker_y_q;
		case (dir_in)
			law_pkg::DIR_XM: mv_x = law_pkg::dec_x(walker_x_q);
			law_pkg::DIR_XP: mv_x = law_pkg::inc_x(walker_x_q);
			law_pkg::DIR_YP: mv_y = law_pkg::inc_y(walker_y_q);
			law_pkg::DIR_YM: mv_y = law_pkg::dec_y(walker_y_q);
			default: begin
				mv_x = walker_x_q;
				mv_y = walker_y_q;
			end
		endcase
		if (op_in == law_pkg::OP_WALK && active_q) begin
			nx_x = mv_x;
			nx_y = mv_y;
		end else if (op_in == law_pkg::OP_WALK || active_q) begin
			nx_x = walker_x_q;
			nx_y = walker_y_q;
		end else begin
			nx_x = law_pkg::XW'(pos_x);
			nx_y = law_pkg::YW'(pos_y);
		end
		need_read = (op_in == law_pkg::OP_ENTER && !active_q) ||
		            (op_in == law_pkg::OP_WALK && active_q);
	end

	// final decision for the word in work
	always_comb begin
		occ_any     = nb_occ_q || (rd_data_q == law_pkg::SITE_OCCUPIED);
		res_status  = law_pkg::ST_WRITTEN;
		do_write    = 1'b0;
		write_val   = law_pkg::SITE_OCCUPIED;
		bump_occ    = 1'b0;
		bump_open   = 1'b0;
		set_active  = 1'b0;
		clr_active  = 1'b0;
		move_walker = 1'b0;
		if (op_q != law_pkg::OP_WALK && active_q) begin
			res_status = law_pkg::ST_BUSY;
		end else begin
			case (op_q)
				law_pkg::OP_SEED: begin
					do_write = 1'b1;
					bump_occ = 1'b1;
				end
				law_pkg::OP_OPEN: begin
					do_write  = 1'b1;
					write_val = law_pkg::SITE_OPEN;
					bump_open = 1'b1;
				end
				law_pkg::OP_ENTER: begin
					if (center_q != law_pkg::SITE_EMPTY) begin
						res_status = law_pkg::ST_REJECTED;
					end else if (occ_any) begin
						res_status = law_pkg::ST_STUCK;
						do_write   = 1'b1;
						bump_occ   = 1'b1;
					end else begin
						res_status  = law_pkg::ST_WALKING;
						set_active  = 1'b1;
						move_walker = 1'b1;
					end
				end
				law_pkg::OP_WALK: begin
					if (!active_q) begin
						res_status = law_pkg::ST_NO_PARTICLE;
					end else begin
						move_walker = 1'b1;
						if (center_q == law_pkg::SITE_OPEN) begin
							res_status = law_pkg::ST_ESCAPED;
							clr_active = 1'b1;
						end else if (occ_any) begin
							res_status = law_pkg::ST_STUCK;
							do_write   = 1'b1;
							bump_occ   = 1'b1;
							clr_active = 1'b1;
						end else begin
							res_status = law_pkg::ST_WALKING;
						end
					end
				end
				default: res_status = law_pkg::ST_BUSY;
			endcase
		end
	end

	// memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {ty_q, tx_q};
		mem_wdata = write_val;
		if (state_q == law_pkg::S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = law_pkg::SITE_EMPTY;
		end else if (state_q == law_pkg::S_FIN && fin_go && do_write) begin
			mem_we = 1'b1;
		end
		mem_re = (state_q == law_pkg::S_READ);
		case (idx_q)
			law_pkg::IDX_W'(1): mem_raddr = {ty_q, law_pkg::dec_x(tx_q)};
			law_pkg::IDX_W'(2): mem_raddr = {ty_q, law_pkg::inc_x(tx_q)};
			law_pkg::IDX_W'(3): mem_raddr = {law_pkg::dec_y(ty_q), tx_q};
			law_pkg::IDX_W'(4): mem_raddr = {law_pkg::inc_y(ty_q), tx_q};
			default:            mem_raddr = {ty_q, tx_q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= grid_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= law_pkg::S_CLEAR;
			idx_q       <= '0;
			clr_addr_q  <= '0;
			active_q    <= 1'b0;
			walker_x_q  <= '0;
			walker_y_q  <= '0;
			occ_cnt_q   <= '0;
			open_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != law_pkg::S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				law_pkg::S_CLEAR: begin
					clr_addr_q <= clr_addr_q + law_pkg::ADDR_W'(1);
					if (clr_addr_q == law_pkg::ADDR_W'(law_pkg::GRID_SITES - 1)) begin
						state_q <= law_pkg::S_IDLE;
					end
				end
				law_pkg::S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= need_read ? law_pkg::S_READ : law_pkg::S_FIN;
					end
				end
				law_pkg::S_READ: begin
					idx_q <= idx_q + law_pkg::IDX_W'(1);
					if (idx_q == law_pkg::IDX_W'(law_pkg::NB_LAST)) begin
						state_q <= law_pkg::S_FIN;
					end
				end
				law_pkg::S_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q     <= law_pkg::S_IDLE;
						if (set_active) begin
							active_q <= 1'b1;
						end else if (clr_active) begin
							active_q <= 1'b0;
						end
						if (move_walker) begin
							walker_x_q <= tx_q;
							walker_y_q <= ty_q;
						end
						if (bump_occ &&
						    occ_cnt_q < law_pkg::CNT_W'(law_pkg::COUNT_LIMIT)) begin
							occ_cnt_q <= occ_cnt_q + law_pkg::CNT_W'(1);
						end
						if (bump_open &&
						    open_cnt_q < law_pkg::CNT_W'(law_pkg::COUNT_LIMIT)) begin
							open_cnt_q <= open_cnt_q + law_pkg::CNT_W'(1);
						end
					end
				end
				default: state_q <= law_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_in;
			tx_q <= nx_x;
			ty_q <= nx_y;
		end
		if (state_q == law_pkg::S_READ) begin
			if (idx_q == law_pkg::IDX_W'(0)) begin
				nb_occ_q <= 1'b0;
			end else if (idx_q == law_pkg::IDX_W'(1)) begin
				center_q <= rd_data_q;
			end else begin
				nb_occ_q <= nb_occ_q || (rd_data_q == law_pkg::SITE_OCCUPIED);
			end
		end
		if (state_q == law_pkg::S_FIN && fin_go) begin
			status_q <= res_status;
			cur_x_q  <= tx_q;
			cur_y_q  <= ty_q;
		end
	end

`ifndef SYNTH
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == law_pkg::S_CLEAR |-> !out_valid_q)
		else $error("result during grid clear");

	a_occ_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		occ_cnt_q <= law_pkg::CNT_W'(law_pkg::COUNT_LIMIT))
		else $error("occupied count above limit");

	a_stuck_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == law_pkg::S_FIN && fin_go && res_status == law_pkg::ST_STUCK)
		|-> mem_we)
		else $error("stuck without grid write");

	a_escape_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == law_pkg::S_FIN && fin_go && res_status == law_pkg::ST_ESCAPED)
		|=> (!active_q && out_valid_q))
		else $error("escaped walker still active");

	a_read_ends_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == law_pkg::S_READ && idx_q == law_pkg::IDX_W'(law_pkg::NB_LAST))
		|=> state_q == law_pkg::S_FIN)
		else $error("neighbor read sequence overran");
`endif

endmodule
